/* design/asd_pkg.sv */
// Shared types and constants for the accepting SCC detector.
// Used by asd_ctrl, asd_datapath and the top level; no dependencies.
package asd_pkg;

  localparam int NODE_W        = 10;
  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 4096;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_MARK   = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic holds;
    logic edge_overflow;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ADD,
    ST_SCHK,
    ST_ENTER,
    ST_HEAD,
    ST_EDGE,
    ST_TGT,
    ST_CHK,
    ST_FIN,
    ST_PW,
    ST_PA,
    ST_RET,
    ST_POPF,
    ST_PLOW,
    ST_REPORT
  } state_e;

  typedef struct packed {
    state_e op;
    logic   take;
  } cmd_t;

  typedef struct packed {
    logic ab_ok;
    logic full;
    logic can_search;
    logic vis_zero;
    logic edge_none;
    logic is_root;
    logic single_pop;
    logic pa_last;
    logic acc_hit;
    logic depth_zero;
    logic sweep_done;
    logic out_busy;
  } stat_t;

endpackage

/* design/asd_ctrl.sv */
// Sequencer for the accepting SCC detector: load items and the SCC walk.
// Depends on asd_pkg; drives asd_datapath through cmd_t, reads stat_t.
module asd_ctrl import asd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  req_t   in_req_i,
  output logic   in_ready_o,
  input  stat_t  stat_i,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o.op   = state_q;
    cmd_o.take = 1'b0;
    case (state_q)
      ST_SWEEP: if (stat_i.sweep_done) state_d = ST_IDLE;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i) begin
          case (in_req_i.mode)
            MODE_CLEAR:  state_d = ST_SWEEP;
            MODE_ADD:    if (stat_i.ab_ok && !stat_i.full) state_d = ST_ADD;
            MODE_MARK:   state_d = ST_IDLE;
            MODE_SEARCH: state_d = stat_i.can_search ? ST_SCHK : ST_REPORT;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD:   state_d = ST_IDLE;
      ST_SCHK:  state_d = stat_i.vis_zero ? ST_ENTER : ST_REPORT;
      ST_ENTER: state_d = ST_HEAD;
      ST_HEAD:  state_d = ST_EDGE;
      ST_EDGE:  state_d = stat_i.edge_none ? ST_FIN : ST_TGT;
      ST_TGT:   state_d = ST_CHK;
      ST_CHK:   state_d = stat_i.vis_zero ? ST_ENTER : ST_EDGE;
      ST_FIN:   state_d = stat_i.is_root ? ST_PW : ST_RET;
      ST_PW:    state_d = stat_i.single_pop ? ST_RET : ST_PA;
      ST_PA: begin
        if (stat_i.pa_last) begin
          state_d = stat_i.acc_hit ? ST_REPORT : ST_RET;
        end else begin
          state_d = ST_PW;
        end
      end
      ST_RET:    state_d = stat_i.depth_zero ? ST_REPORT : ST_POPF;
      ST_POPF:   state_d = ST_PLOW;
      ST_PLOW:   state_d = ST_EDGE;
      ST_REPORT: if (!stat_i.out_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

endmodule

/* design/asd_datapath.sv */
// Graph stores, Tarjan stacks, counters and result register of the detector.
// Depends on asd_pkg; every action is selected by the command from asd_ctrl.
module asd_datapath import asd_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cmd_t   cmd_i,
  input  req_t   req_i,
  input  logic   out_ready_i,
  output stat_t  stat_o,
  output logic   out_valid_o,
  output rsp_t   out_rsp_o
);

  localparam int NAW = $clog2(MAX_NODES);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int LW  = EAW + 1;
  localparam int OW  = $clog2(MAX_NODES + 1);
  localparam logic [LW-1:0] NoneLink = '1;

  // stores
  logic [NODE_W-1:0] etgt_mem  [MAX_EDGES];
  logic [LW-1:0]     elink_mem [MAX_EDGES];
  logic [LW-1:0]     head_mem  [MAX_NODES];
  logic [OW-1:0]     vis_mem   [MAX_NODES];
  logic [OW-1:0]     low_mem   [MAX_NODES];
  logic              on_mem    [MAX_NODES];
  logic              acc_mem   [MAX_NODES];
  logic [NODE_W-1:0] stk_mem   [MAX_NODES];
  logic [NODE_W-1:0] cn_mem    [MAX_NODES];
  logic [LW-1:0]     ce_mem    [MAX_NODES];

  logic [NODE_W-1:0] etgt_rd, stk_rd, cn_rd;
  logic [LW-1:0]     elink_rd, head_rd, ce_rd;
  logic [OW-1:0]     vis_rd, low_rd;
  logic              on_rd, acc_rd;

  // control registers
  logic [LW-1:0]  cnt_q;
  logic [OW-1:0]  ord_q, sp_q, depth_q;
  logic [NAW-1:0] sw_q;
  logic           verdict_q, ovf_q, out_valid_q;
  // payload registers
  logic [NODE_W-1:0] a_q, b_q, tgt_q, cur_v_q, w_q;
  logic [LW-1:0]     cur_e_q;
  logic [OW-1:0]     cur_low_q, cur_vis_q, child_low_q;
  logic              first_q, acc_q;
  rsp_t              out_q;

  logic a_ok, b_ok, take_clear, take_add, take_mark, low_upd, acc_new;
  logic [OW-1:0] ord_inc, plow_min;

  assign a_ok       = 32'(req_i.node_a) < 32'(MAX_NODES);
  assign b_ok       = 32'(req_i.node_b) < 32'(MAX_NODES);
  assign take_clear = cmd_i.take && (req_i.mode == MODE_CLEAR);
  assign take_add   = cmd_i.take && (req_i.mode == MODE_ADD) && a_ok && b_ok;
  assign take_mark  = cmd_i.take && (req_i.mode == MODE_MARK) && a_ok;
  assign ord_inc    = ord_q + OW'(1);
  assign low_upd    = (vis_rd != '0) && on_rd && (low_rd < cur_low_q);
  assign acc_new    = acc_q | acc_rd;
  assign plow_min   = (child_low_q < low_rd) ? child_low_q : low_rd;

  assign stat_o.ab_ok      = a_ok && b_ok;
  assign stat_o.full       = cnt_q == LW'(MAX_EDGES);
  assign stat_o.can_search = verdict_q && a_ok;
  assign stat_o.vis_zero   = vis_rd == '0;
  assign stat_o.edge_none  = cur_e_q[LW-1];
  assign stat_o.is_root    = cur_low_q == cur_vis_q;
  assign stat_o.single_pop = first_q && (stk_rd == cur_v_q);
  assign stat_o.pa_last    = w_q == cur_v_q;
  assign stat_o.acc_hit    = acc_new;
  assign stat_o.depth_zero = depth_q == '0;
  assign stat_o.sweep_done = sw_q == NAW'(MAX_NODES - 1);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // edge store
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ST_ADD) begin
      etgt_mem[cnt_q[EAW-1:0]]  <= b_q;
      elink_mem[cnt_q[EAW-1:0]] <= head_rd;
    end
    etgt_rd  <= etgt_mem[cur_e_q[EAW-1:0]];
    elink_rd <= elink_mem[cur_e_q[EAW-1:0]];
  end

  // list heads
  logic           head_we;
  logic [NAW-1:0] head_wa, head_ra;
  logic [LW-1:0]  head_wd;
  always_comb begin
    head_we = 1'b0;
    head_wa = sw_q;
    head_wd = NoneLink;
    head_ra = NAW'(tgt_q);
    if (cmd_i.op == ST_SWEEP) begin
      head_we = 1'b1;
    end else if (cmd_i.op == ST_ADD) begin
      head_we = 1'b1;
      head_wa = NAW'(a_q);
      head_wd = cnt_q;
    end
    if (cmd_i.op == ST_IDLE) head_ra = NAW'(req_i.node_a);
  end
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end

  // visit order and low link share a read address
  logic           vis_we, low_we;
  logic [NAW-1:0] vis_wa, low_wa, node_ra;
  logic [OW-1:0]  vis_wd, low_wd;
  always_comb begin
    vis_we  = 1'b0;
    vis_wa  = sw_q;
    vis_wd  = '0;
    low_we  = 1'b0;
    low_wa  = sw_q;
    low_wd  = '0;
    case (cmd_i.op)
      ST_SWEEP: begin
        vis_we = 1'b1;
        low_we = 1'b1;
      end
      ST_ENTER: begin
        vis_we = 1'b1;
        vis_wa = NAW'(tgt_q);
        vis_wd = ord_inc;
        low_we = 1'b1;
        low_wa = NAW'(tgt_q);
        low_wd = ord_inc;
      end
      ST_CHK: begin
        low_we = low_upd;
        low_wa = NAW'(cur_v_q);
        low_wd = low_rd;
      end
      ST_PLOW: begin
        low_we = child_low_q < low_rd;
        low_wa = NAW'(cur_v_q);
        low_wd = child_low_q;
      end
      default: ;
    endcase
    case (cmd_i.op)
      ST_IDLE: node_ra = NAW'(req_i.node_a);
      ST_POPF: node_ra = NAW'(cn_rd);
      default: node_ra = NAW'(etgt_rd);
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (low_we) low_mem[low_wa] <= low_wd;
    vis_rd <= vis_mem[node_ra];
    low_rd <= low_mem[node_ra];
  end

  // on-stack flags
  logic           on_we, on_wd;
  logic [NAW-1:0] on_wa;
  always_comb begin
    on_we = 1'b0;
    on_wa = sw_q;
    on_wd = 1'b0;
    case (cmd_i.op)
      ST_SWEEP: on_we = 1'b1;
      ST_ENTER: begin
        on_we = 1'b1;
        on_wa = NAW'(tgt_q);
        on_wd = 1'b1;
      end
      ST_PW: begin
        on_we = stat_o.single_pop;
        on_wa = NAW'(cur_v_q);
      end
      ST_PA: begin
        on_we = 1'b1;
        on_wa = NAW'(w_q);
      end
      default: ;
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (on_we) on_mem[on_wa] <= on_wd;
    on_rd <= on_mem[NAW'(etgt_rd)];
  end

  // accepting flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ST_SWEEP) begin
      acc_mem[sw_q] <= 1'b0;
    end else if (take_mark) begin
      acc_mem[NAW'(req_i.node_a)] <= 1'b1;
    end
    acc_rd <= acc_mem[NAW'(stk_rd)];
  end

  // SCC stack: read the top on finish, the next one down while popping
  logic [OW-1:0] stk_ra;
  assign stk_ra = (cmd_i.op == ST_PA) ? (sp_q - OW'(2)) : (sp_q - OW'(1));
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ST_ENTER) stk_mem[NAW'(sp_q)] <= tgt_q;
    stk_rd <= stk_mem[NAW'(stk_ra)];
  end

  // call stack of parent frames
  logic [OW-1:0] depth_dec;
  assign depth_dec = depth_q - OW'(1);
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ST_CHK && vis_rd == '0) begin
      cn_mem[NAW'(depth_q)] <= cur_v_q;
      ce_mem[NAW'(depth_q)] <= cur_e_q;
    end
    cn_rd <= cn_mem[NAW'(depth_dec)];
    ce_rd <= ce_mem[NAW'(depth_dec)];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ord_q       <= '0;
      sp_q        <= '0;
      depth_q     <= '0;
      sw_q        <= '0;
      verdict_q   <= 1'b1;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == ST_REPORT && !stat_o.out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take_clear) begin
        cnt_q     <= '0;
        ord_q     <= '0;
        sp_q      <= '0;
        depth_q   <= '0;
        sw_q      <= '0;
        verdict_q <= 1'b1;
        ovf_q     <= 1'b0;
      end
      if (take_add && stat_o.full) ovf_q <= 1'b1;
      if (cmd_i.take && req_i.mode == MODE_SEARCH) depth_q <= '0;
      case (cmd_i.op)
        ST_SWEEP: if (!stat_o.sweep_done) sw_q <= sw_q + NAW'(1);
        ST_ADD:   cnt_q <= cnt_q + LW'(1);
        ST_ENTER: begin
          ord_q <= ord_inc;
          sp_q  <= sp_q + OW'(1);
        end
        ST_CHK:   if (vis_rd == '0) depth_q <= depth_q + OW'(1);
        ST_PW:    if (stat_o.single_pop) sp_q <= sp_q - OW'(1);
        ST_PA: begin
          sp_q <= sp_q - OW'(1);
          if (stat_o.pa_last && acc_new) verdict_q <= 1'b0;
        end
        ST_RET:   if (depth_q != '0) depth_q <= depth_dec;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      a_q   <= req_i.node_a;
      b_q   <= req_i.node_b;
      tgt_q <= req_i.node_a;
    end
    case (cmd_i.op)
      ST_ENTER: begin
        cur_v_q   <= tgt_q;
        cur_low_q <= ord_inc;
        cur_vis_q <= ord_inc;
      end
      ST_HEAD: cur_e_q <= head_rd;
      ST_TGT: begin
        tgt_q   <= etgt_rd;
        cur_e_q <= elink_rd;
      end
      ST_CHK: if (low_upd) cur_low_q <= low_rd;
      ST_FIN: begin
        first_q <= 1'b1;
        acc_q   <= 1'b0;
      end
      ST_PW: w_q <= stk_rd;
      ST_PA: begin
        acc_q   <= acc_new;
        first_q <= 1'b0;
      end
      ST_RET: child_low_q <= cur_low_q;
      ST_POPF: begin
        cur_v_q <= cn_rd;
        cur_e_q <= ce_rd;
      end
      ST_PLOW: begin
        cur_vis_q <= vis_rd;
        cur_low_q <= plow_min;
      end
      ST_REPORT: begin
        // hold the waiting result until it is taken
        if (!stat_o.out_busy) begin
          out_q.holds         <= verdict_q;
          out_q.edge_overflow <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= OW'(MAX_NODES)) else $error("scc stack beyond node count");
  a_depth_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= sp_q) else $error("call frames exceed scc stack");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LW'(MAX_EDGES)) else $error("edge count beyond capacity");
  a_ord_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ord_q <= OW'(MAX_NODES)) else $error("visit order beyond node count");

endmodule

/* design/accepting_scc_detector_unit.sv */
// Accepting SCC detector: requests add an edge, mark a node, clear, or search.
// A search with the verdict already cleared, or from a visited node, reports without a walk;
// from a new node it starts a serial Tarjan walk that stops at an accepting multi-node SCC.
// One request at a time; a search result waits in an output register.
// Reset (async, active low) starts a sweep clearing the node stores, as a clear does;
// requests are held off until it ends.
module accepting_scc_detector_unit import asd_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  asd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  asd_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_req_i),
    .out_ready_i (out_ready_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

/* tb/tb_accepting_scc_detector_unit.sv */
// Testbench for accepting_scc_detector_unit: graph loads, marks, clears and searches.
// Holds its own Tarjan walk to predict each search verdict; depends on asd_pkg.
module tb_accepting_scc_detector_unit;
  import asd_pkg::*;

  localparam int NN = MAX_NODES_DEF;
  localparam int NE = MAX_EDGES_DEF;
  localparam int NIL = 32'hFFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;

  accepting_scc_detector_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_rsp_o
  );

  always #5 clk_i = ~clk_i;

  // Graph model
  int g_tgt[NE];
  int g_next[NE];
  int g_head[NN];
  int g_order[NN];
  int g_low[NN];
  int g_stk[NN];
  bit g_onstk[NN];
  bit g_acc[NN];
  int g_cnode[NN];
  int g_cedge[NN];
  int g_ecount, g_ocount, g_top, g_depth;
  bit g_verdict, g_ovf;

  rsp_t verdict_q[$];
  int mismatches = 0;
  bit busy_burst = 1'b0;

  function automatic void graph_clear();
    for (int i = 0; i < NN; i++) begin
      g_head[i] = NIL; g_order[i] = 0; g_low[i] = 0; g_onstk[i] = 0; g_acc[i] = 0;
    end
    g_ecount = 0; g_ocount = 0; g_top = 0; g_depth = 0;
    g_verdict = 1; g_ovf = 0;
  endfunction

  function automatic void visit_node(int v);
    if (g_depth >= NN || g_top >= NN) return;
    g_ocount++;
    g_order[v] = g_ocount;
    g_low[v] = g_ocount;
    g_stk[g_top++] = v;
    g_onstk[v] = 1;
    g_cnode[g_depth] = v;
    g_cedge[g_depth] = g_head[v];
    g_depth++;
  endfunction

  // Return 0 when an accepting multi-node component closes at v.
  function automatic bit close_node(int v);
    bit acc;
    int w;
    acc = 0;
    if (g_low[v] != g_order[v] || g_top == 0) return 1;
    if (g_stk[g_top-1] == v) begin
      g_onstk[v] = 0; g_top--; return 1;
    end
    while (g_top > 0) begin
      w = g_stk[g_top-1];
      if (g_acc[w]) acc = 1;
      g_onstk[w] = 0;
      g_top--;
      if (w == v) break;
    end
    return !acc;
  endfunction

  function automatic void tarjan_walk(int start);
    int d, v, e, w, p;
    g_depth = 0;
    visit_node(start);
    while (g_depth > 0) begin
      d = g_depth - 1; v = g_cnode[d]; e = g_cedge[d];
      if (e != NIL && e < g_ecount) begin
        w = g_tgt[e];
        g_cedge[d] = g_next[e];
        if (g_order[w] == 0) visit_node(w);
        else if (g_onstk[w] && g_low[w] < g_low[v]) g_low[v] = g_low[w];
      end else begin
        if (!close_node(v)) begin
          g_verdict = 0; g_depth = 0; return;
        end
        g_depth--;
        if (g_depth > 0) begin
          p = g_cnode[g_depth-1];
          if (g_low[v] < g_low[p]) g_low[p] = g_low[v];
        end
      end
    end
  endfunction

  function automatic void predict_request(req_t r);
    rsp_t x;
    case (r.mode)
      MODE_CLEAR: graph_clear();
      MODE_ADD: begin
        if (g_ecount >= NE) g_ovf = 1;
        else begin
          g_tgt[g_ecount] = r.node_b;
          g_next[g_ecount] = g_head[r.node_a];
          g_head[r.node_a] = g_ecount;
          g_ecount++;
        end
      end
      MODE_MARK: g_acc[r.node_a] = 1;
      default: begin
        if (g_verdict && g_order[r.node_a] == 0) tarjan_walk(r.node_a);
        x.holds = g_verdict;
        x.edge_overflow = g_ovf;
        verdict_q = {verdict_q, x};
      end
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(mode_e m, int a, int b);
    req_t r;
    int gap;
    r.mode = m; r.node_a = a[NODE_W-1:0]; r.node_b = b[NODE_W-1:0];
    gap = busy_burst ? 0 : gap_len();
    // keep valid high when this request follows the last one at once
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(r);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (verdict_q.size() > 0 && guard < 2000000) begin
      @(posedge clk_i); guard++;
    end
    repeat (NN + 20) @(posedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %b", out_rsp_o);
      end else begin
        rsp_t x;
        x = verdict_q.pop_front();
        if (x !== out_rsp_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected holds=%b ovf=%b got holds=%b ovf=%b",
                     x.holds, x.edge_overflow, out_rsp_o.holds, out_rsp_o.edge_overflow);
        end
      end
    end
  end

  // Receiver stalls
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      n = busy_burst ? 0 : gap_len();
      if (n == 0) out_ready_i <= 1'b1;
      else begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_request(MODE_SEARCH, 0, 0);          // empty graph
    send_request(MODE_ADD, 1, 2);
    send_request(MODE_ADD, 2, 1);
    send_request(MODE_ADD, 3, 3);             // self-loop stays single-node
    send_request(MODE_MARK, 3, 1023);
    send_request(MODE_SEARCH, 3, 0);
    send_request(MODE_SEARCH, 3, 0);          // already visited
    send_request(MODE_ADD, 1023, 0);
    send_request(MODE_ADD, 0, 1023);
    send_request(MODE_MARK, 1023, 0);
    send_request(MODE_SEARCH, 1023, 0);       // accepting pair
    send_request(MODE_SEARCH, 5, 0);          // verdict already cleared
    send_request(MODE_CLEAR, 1023, 1023);
    send_request(MODE_MARK, 2, 0);
    send_request(MODE_SEARCH, 1, 0);          // single node with no edges after the clear
    send_request(MODE_SEARCH, 2, 0);
  endtask

  task automatic test_edge_burst();
    send_request(MODE_CLEAR, 0, 0);
    busy_burst = 1'b1;
    for (int i = 0; i < 300; i++) send_request(MODE_ADD, i % 8, $urandom_range(0, 7));
    busy_burst = 1'b0;
    send_request(MODE_SEARCH, 0, 0);
    send_request(MODE_CLEAR, 0, 0);
    send_request(MODE_SEARCH, 4, 0);
  endtask

  task automatic test_random_graphs();
    int n, span, base;
    for (int g = 0; g < 60; g++) begin
      span = $urandom_range(2, 12);
      base = ($urandom_range(0, 9) == 0) ? 1024 - span : $urandom_range(0, 1023 - span);
      send_request(MODE_CLEAR, $urandom, $urandom);
      n = $urandom_range(2, 20);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0, 1: send_request(MODE_MARK, base + $urandom_range(0, span), $urandom);
          2: send_request(MODE_SEARCH, base + $urandom_range(0, span), $urandom);
          3: send_request(MODE_ADD, $urandom, $urandom);
          default: send_request(MODE_ADD, base + $urandom_range(0, span),
                                base + $urandom_range(0, span));
        endcase
      end
      for (int i = 0; i < 3; i++) send_request(MODE_SEARCH, base + $urandom_range(0, span), 0);
      if (g == 30) drain();  // pause the sender until all verdicts are back
    end
  endtask

  initial begin
    graph_clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_edge_burst();
    test_random_graphs();
    drain();
    if (mismatches == 0 && verdict_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
